// ----- design/utf8_to_utf16_transcoder_core_macros.svh -----
// assertion helpers shared by the transcoder modules
// every user has i_clk and an active-low i_rst_n
`ifndef UTF8_TO_UTF16_TRANSCODER_CORE_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_CORE_MACROS_SVH

// consequent must hold in the same cycle
`define U2U_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the following cycle
`define U2U_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/u2u_pkg.sv -----
package u2u_pkg;

    localparam int BYTE_W = 8;
    localparam int UNIT_W = 21;
    localparam int CNT_W  = 3;
    localparam int LEN_W  = 3;
    localparam int DEPTH  = 4;

    localparam logic [UNIT_W-1:0] REPLACEMENT = 21'h00FFFD;

    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_VAL  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_VAL  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_VAL  = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_VAL   = 8'h80;

    localparam logic [UNIT_W-1:0] MIN_CP2    = 21'h000080;
    localparam logic [UNIT_W-1:0] MIN_CP3    = 21'h000800;
    localparam logic [UNIT_W-1:0] MIN_CP4    = 21'h010000;
    localparam logic [UNIT_W-1:0] SURR_LO    = 21'h00D800;
    localparam logic [UNIT_W-1:0] SURR_HI    = 21'h00DFFF;
    localparam logic [UNIT_W-1:0] MAX_CP     = 21'h10FFFF;
    localparam logic [UNIT_W-1:0] BMP_MAX    = 21'h00FFFF;
    localparam logic [UNIT_W-1:0] PLANE_BASE = 21'h010000;
    localparam logic [15:0]       HI_BASE    = 16'hD800;
    localparam logic [15:0]       LO_BASE    = 16'hDC00;

    localparam logic [LEN_W-1:0] LEN_BAD = 3'd0;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic emit_one;
        logic emit_hi;
        logic emit_lo;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic emit;
        logic pair;
        logic more;
        logic out_free;
    } t_status;

    // sequence length announced by a lead byte, LEN_BAD for an illegal lead
    function automatic logic [LEN_W-1:0] seq_len(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] len;
        priority if (!b[BYTE_W-1])                   len = 3'd1;
        else if ((b & LEAD2_MASK) == LEAD2_VAL)      len = 3'd2;
        else if ((b & LEAD3_MASK) == LEAD3_VAL)      len = 3'd3;
        else if ((b & LEAD4_MASK) == LEAD4_VAL)      len = 3'd4;
        else                                         len = LEN_BAD;
        return len;
    endfunction

endpackage

// ----- design/u2u_if.sv -----
interface u2u_in_if;
    import u2u_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface u2u_out_if;
    import u2u_pkg::*;
    logic              valid;
    logic              ready;
    logic [UNIT_W-1:0] out_unit;
    logic              out_replaced;
    logic              out_run_last;
    modport source (output valid, output out_unit, output out_replaced,
                    output out_run_last, input ready);
    modport sink   (input valid, input out_unit, input out_replaced,
                    input out_run_last, output ready);
endinterface

interface u2u_cfg_if;
    logic valid;
    logic ready;
    logic utf16_output;
    modport source (output valid, output utf16_output, input ready);
    modport sink   (input valid, input utf16_output, output ready);
endinterface

// ----- design/u2u_datapath.sv -----
`include "utf8_to_utf16_transcoder_core_macros.svh"

module u2u_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [u2u_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                         i_in_last,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_utf16,
    input  u2u_pkg::t_cmd                i_cmd,
    output u2u_pkg::t_status             o_status,
    u2u_out_if.source                    o_out
);
    import u2u_pkg::*;

    logic [BYTE_W-1:0] r_buf [DEPTH];
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_last;
    logic              r_utf16;
    logic              r_out_valid, n_out_valid;
    logic [UNIT_W-1:0] r_out_unit, n_out_unit;
    logic              r_out_rep, n_out_rep;
    logic              r_out_run_last, n_out_run_last;

    logic [BYTE_W-1:0] lead, next_lead;
    logic [LEN_W-1:0]  len, next_len, drop_k;
    logic              bad_lead, full, cont_ok, overlong, surr, big, seq_ok, trunc;
    logic [UNIT_W-1:0] cp, v;
    logic [15:0]       hi_unit, lo_unit;
    logic [CNT_W-1:0]  rem;
    logic              out_free;

    assign lead     = r_buf[0];
    assign len      = seq_len(lead);
    assign bad_lead = (len == LEN_BAD);
    assign full     = (r_count >= len);

    always_comb begin
        cont_ok = 1'b1;
        if (len >= 3'd2 && (r_buf[1] & CONT_MASK) != CONT_VAL) cont_ok = 1'b0;
        if (len >= 3'd3 && (r_buf[2] & CONT_MASK) != CONT_VAL) cont_ok = 1'b0;
        if (len >= 3'd4 && (r_buf[3] & CONT_MASK) != CONT_VAL) cont_ok = 1'b0;
    end

    always_comb begin
        unique case (len)
            3'd1:    cp = {13'd0, lead};
            3'd2:    cp = {10'd0, lead[4:0], r_buf[1][5:0]};
            3'd3:    cp = {5'd0, lead[3:0], r_buf[1][5:0], r_buf[2][5:0]};
            3'd4:    cp = {lead[2:0], r_buf[1][5:0], r_buf[2][5:0], r_buf[3][5:0]};
            default: cp = '0;
        endcase
    end

    assign overlong = (len == 3'd2 && cp < MIN_CP2) || (len == 3'd3 && cp < MIN_CP3)
                   || (len == 3'd4 && cp < MIN_CP4);
    assign surr     = (cp >= SURR_LO) && (cp <= SURR_HI);
    assign big      = (cp > MAX_CP);
    assign seq_ok   = !bad_lead && full && cont_ok && !overlong && !surr && !big;
    assign trunc    = !bad_lead && !full;
    assign drop_k   = seq_ok ? len : 3'd1;

    assign v       = cp - PLANE_BASE;
    assign hi_unit = HI_BASE + {6'd0, v[19:10]};
    assign lo_unit = LO_BASE + {6'd0, v[9:0]};

    // lookahead: does the buffer left after this unit yield another one
    assign rem       = (drop_k >= r_count) ? '0 : r_count - drop_k;
    assign next_lead = r_buf[drop_k[1:0]];
    assign next_len  = seq_len(next_lead);

    assign out_free = !r_out_valid || o_out.ready;

    assign o_status.emit     = (r_count != '0) && (bad_lead || full || r_last);
    assign o_status.pair     = seq_ok && r_utf16 && (cp > BMP_MAX);
    assign o_status.more     = !trunc && (rem != '0)
                            && (next_len == LEN_BAD || rem >= next_len || r_last);
    assign o_status.out_free = out_free;

    always_comb begin
        n_count        = r_count;
        n_out_valid    = r_out_valid && !o_out.ready;
        n_out_unit     = r_out_unit;
        n_out_rep      = r_out_rep;
        n_out_run_last = r_out_run_last;
        if (i_cmd.load) begin
            n_count = r_count + 3'd1;
        end
        if (i_cmd.emit_one) begin
            n_out_valid    = 1'b1;
            n_out_unit     = seq_ok ? cp : REPLACEMENT;
            n_out_rep      = !seq_ok;
            n_out_run_last = !o_status.more;
            n_count        = trunc ? '0 : rem;
        end
        if (i_cmd.emit_hi) begin
            n_out_valid    = 1'b1;
            n_out_unit     = {5'd0, hi_unit};
            n_out_rep      = 1'b0;
            n_out_run_last = 1'b0;
        end
        if (i_cmd.emit_lo) begin
            n_out_valid    = 1'b1;
            n_out_unit     = {5'd0, lo_unit};
            n_out_rep      = 1'b0;
            n_out_run_last = 1'b1;
            n_count        = rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_last      <= 1'b0;
            r_utf16     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cmd.load) r_last <= i_in_last;
            if (i_cfg_valid) r_utf16 <= i_cfg_utf16;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_unit     <= n_out_unit;
        r_out_rep      <= n_out_rep;
        r_out_run_last <= n_out_run_last;
        if (i_cmd.load) begin
            r_buf[r_count[1:0]] <= i_in_byte;
        end else if (i_cmd.emit_one && !trunc) begin
            // slide the unread bytes to the front
            unique case (drop_k)
                3'd1: begin
                    r_buf[0] <= r_buf[1];
                    r_buf[1] <= r_buf[2];
                    r_buf[2] <= r_buf[3];
                end
                3'd2: begin
                    r_buf[0] <= r_buf[2];
                    r_buf[1] <= r_buf[3];
                end
                3'd3: begin
                    r_buf[0] <= r_buf[3];
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_unit     = r_out_unit;
    assign o_out.out_replaced = r_out_rep;
    assign o_out.out_run_last = r_out_run_last;

    `U2U_ASSERT_SAME(a_emit_slot_free, i_cmd.emit_one || i_cmd.emit_hi || i_cmd.emit_lo,
        out_free, "unit written over a waiting result")
    `U2U_ASSERT_NEXT(a_low_empties, i_cmd.emit_lo, r_count == '0,
        "buffer not empty after surrogate pair")
    `U2U_ASSERT_SAME(a_no_overflow, i_cmd.load, r_count < 3'd4,
        "byte loaded into a full buffer")

endmodule

// ----- design/u2u_ctrl.sv -----
`include "utf8_to_utf16_transcoder_core_macros.svh"

module u2u_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  u2u_pkg::t_status i_status,
    output u2u_pkg::t_cmd    o_cmd
);
    import u2u_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_LOW  = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_status.emit) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    if (i_status.pair) begin
                        o_cmd.emit_hi = 1'b1;
                        n_state       = S_LOW;
                    end else begin
                        o_cmd.emit_one = 1'b1;
                        if (!i_status.more) n_state = S_IDLE;
                    end
                end
            end
            S_LOW: begin
                if (i_status.out_free) begin
                    o_cmd.emit_lo = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `U2U_ASSERT_NEXT(a_load_scans, i_in_valid && o_in_ready, r_state == S_SCAN,
        "accepted byte not scanned")
    `U2U_ASSERT_NEXT(a_pair_low, (r_state == S_SCAN) && o_cmd.emit_hi, r_state == S_LOW,
        "high surrogate without low half")
    `U2U_ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0(o_cmd),
        "more than one command in a cycle")

endmodule

// ----- design/utf8_to_utf16_transcoder_core.sv -----
// utf-8 to utf-16 / utf-32 transcoder
// i_in takes one utf-8 byte per beat with in_last marking the end of the text.
// o_out gives one unit per beat: a utf-16 unit (surrogate pairs above the
// basic plane) or a whole code point, set by utf16_output on i_cfg.
// out_replaced flags a u+fffd standing for bad input; out_run_last marks the
// final unit caused by an input byte. a byte that only extends a sequence
// gives no unit at all.
// i_cfg is always ready; write it only while the block is idle.
// flow: a byte is accepted into the byte buffer, then the controller scans
// the buffer in S_SCAN one unit per cycle while the output register is free;
// a surrogate pair is written as its high half from S_SCAN and its low half
// from S_LOW. every unit passes through the output register to o_out.
// the output register holds a unit until taken; a stalled sink freezes the
// scan, and a new byte is accepted only after the scan of the last one ends.
// reset (synchronous, active low) empties the byte buffer and the output
// register and sets utf16_output to 1.
module utf8_to_utf16_transcoder_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    u2u_in_if.sink    i_in,
    u2u_cfg_if.sink   i_cfg,
    u2u_out_if.source o_out
);
    import u2u_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    u2u_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    u2u_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_byte   (i_in.in_byte),
        .i_in_last   (i_in.in_last),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_utf16 (i_cfg.utf16_output),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out       (o_out)
    );

endmodule
